@@ hdl/timed_key_history_wildcard_match_defines.svh @@
`ifndef TIMED_KEY_HISTORY_WILDCARD_MATCH_DEFINES_SVH
`define TIMED_KEY_HISTORY_WILDCARD_MATCH_DEFINES_SVH

// checks that a condition is followed by an outcome on the next clock
`define THK_ASSERT_NEXT(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

// checks that a condition holds together with an outcome in the same clock
`define THK_ASSERT_SAME(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

`endif

@@ hdl/thk_pkg.sv @@
`default_nettype none

package thk_pkg;

  // default sizes of the history
  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int MAX_PATTERN_DEF   = 8;
  localparam int KEY_BITS_DEF      = 4;

  // fixed field widths
  localparam int KIND_W     = 3;
  localparam int CODE_W     = 4;
  localparam int STAMP_W    = 32;
  localparam int PAT_WORD_W = 32;
  localparam int PLEN_W     = 4;
  localparam int FLEX_W     = 8;
  localparam int AGE_W      = 16;
  localparam int KEEP_W     = 5;
  localparam int START_W    = 4;
  localparam int COUNT_W    = 5;

  localparam logic [AGE_W-1:0] LIFESPAN_RESET = 16'd300;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_KEEP   = 3'd4;

  // per-cell control
  typedef struct packed {
    logic load;
    logic shift;
    logic capture;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ hdl/thk_cell.sv @@
`default_nettype none

module thk_cell #(
  parameter int KEY_BITS    = 4,
  parameter int MAX_PATTERN = 8
) (
  input  wire                                  clk,
  input  thk_pkg::cell_ctl_t                   ctl,
  input  wire  [KEY_BITS-1:0]                  new_key,
  input  wire  [thk_pkg::STAMP_W-1:0]          new_stamp,
  input  wire  [KEY_BITS-1:0]                  up_key,
  input  wire  [thk_pkg::STAMP_W-1:0]          up_stamp,
  input  wire  [thk_pkg::STAMP_W-1:0]          now_ms,
  input  wire  [thk_pkg::AGE_W-1:0]            limit,
  input  wire  [MAX_PATTERN-1:0][KEY_BITS-1:0] pat_keys,
  output logic [KEY_BITS-1:0]                  key,
  output logic [thk_pkg::STAMP_W-1:0]          stamp,
  output logic                                 age_ok,
  output logic [MAX_PATTERN-1:0]               key_eq
);
  import thk_pkg::*;

  logic [STAMP_W-1:0] age;

  // wrapping age of the held entry
  assign age = now_ms - stamp;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key   <= new_key;
      stamp <= new_stamp;
    end else if (ctl.shift) begin
      key   <= up_key;
      stamp <= up_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      age_ok <= (age <= {{(STAMP_W-AGE_W){1'b0}}, limit});
      for (int i = 0; i < MAX_PATTERN; i++) begin
        key_eq[i] <= (key == pat_keys[i]);
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/thk_window.sv @@
`default_nettype none

module thk_window #(
  parameter int HISTORY_DEPTH = 16,
  parameter int MAX_PATTERN   = 8,
  parameter int CNT_W         = 5,
  parameter int IDX_W         = 4
) (
  input  wire  [HISTORY_DEPTH-1:0]                  age_ok,
  input  wire  [HISTORY_DEPTH-1:0][MAX_PATTERN-1:0] key_eq,
  input  wire  [thk_pkg::PLEN_W-1:0]                plen,
  input  wire  [thk_pkg::FLEX_W-1:0]                flex,
  input  wire  [CNT_W-1:0]                          held,
  output logic                                      hit,
  output logic [IDX_W-1:0]                          hit_start,
  output logic [thk_pkg::FLEX_W-1:0]                hit_used
);
  import thk_pkg::*;

  localparam int CW = CNT_W + 5;

  logic [MAX_PATTERN-1:0]                    flex_ext;
  logic [MAX_PATTERN-1:0]                    active;
  logic                                      len_ok;
  logic [HISTORY_DEPTH-1:0][MAX_PATTERN-1:0] pos_fail;
  logic [HISTORY_DEPTH-1:0][MAX_PATTERN-1:0] pos_used;
  logic [HISTORY_DEPTH-1:0]                  win_ok;

  assign len_ok = (plen != '0) && (CW'(plen) <= CW'(MAX_PATTERN)) && (CW'(plen) <= CW'(held));

  genvar s, i;
  generate
    for (i = 0; i < MAX_PATTERN; i++) begin : g_pos
      if (i < FLEX_W) begin : g_flex
        assign flex_ext[i] = flex[i];
      end else begin : g_noflex
        assign flex_ext[i] = 1'b0;
      end
      assign active[i] = (CW'(i) < CW'(plen));
    end

    for (s = 0; s < HISTORY_DEPTH; s++) begin : g_win
      for (i = 0; i < MAX_PATTERN; i++) begin : g_tap
        if (s + i < HISTORY_DEPTH) begin : g_in
          assign pos_fail[s][i] = active[i] &&
                                  (!age_ok[s+i] || (!key_eq[s+i][i] && !flex_ext[i]));
          assign pos_used[s][i] = active[i] && !key_eq[s+i][i] && flex_ext[i];
        end else begin : g_out
          assign pos_fail[s][i] = active[i];
          assign pos_used[s][i] = 1'b0;
        end
      end
      assign win_ok[s] = len_ok && (CW'(s) + CW'(plen) <= CW'(held)) && !(|pos_fail[s]);
    end
  endgenerate

  // first window from the oldest entry wins
  always_comb begin
    hit       = 1'b0;
    hit_start = '0;
    hit_used  = '0;
    for (int w = HISTORY_DEPTH - 1; w >= 0; w--) begin
      if (win_ok[w]) begin
        hit       = 1'b1;
        hit_start = IDX_W'(w);
        for (int j = 0; j < FLEX_W; j++) begin
          hit_used[j] = (j < MAX_PATTERN) ? pos_used[w][j % MAX_PATTERN] : 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/timed_key_history_wildcard_match.sv @@
`default_nettype none

// timed key history with wildcard window match. a row of cells holds the
// history in age order, cell 0 the oldest; full pushes, removals and trims
// move the words one cell down per clock. a word is taken when start is high
// and busy is low, and each word yields one result, shown for a single cycle
// with done high; the receiver cannot stall, so results must be taken as
// they come. push, clear, remove oldest and unknown kinds answer on the next
// cycle, and a new word may be started in that same cycle. a match query
// first has the cells capture age and key compares, then the window picker
// chooses the first matching window. a keep newest that trims shifts the
// cell row once per cycle until keep_count entries are left; a keep newest
// that trims nothing answers on the next cycle. cfg_write loads the default
// lifespan (reset 300 ms); the user must write it only while the block is
// idle, and the block itself does not enforce this
module timed_key_history_wildcard_match #(
  parameter int HISTORY_DEPTH = thk_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_PATTERN   = thk_pkg::MAX_PATTERN_DEF,
  parameter int KEY_BITS      = thk_pkg::KEY_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  output logic                             busy,
  input  wire  [thk_pkg::KIND_W-1:0]       kind,
  input  wire  [thk_pkg::CODE_W-1:0]       key_code,
  input  wire  [thk_pkg::STAMP_W-1:0]      now_ms,
  input  wire  [thk_pkg::PAT_WORD_W-1:0]   pattern_keys,
  input  wire  [thk_pkg::PLEN_W-1:0]       pattern_length,
  input  wire  [thk_pkg::FLEX_W-1:0]       flex_mask,
  input  wire  [thk_pkg::AGE_W-1:0]        max_age_ms,
  input  wire  [thk_pkg::KEEP_W-1:0]       keep_count,
  input  wire                              cfg_write,
  input  wire  [thk_pkg::AGE_W-1:0]        cfg_data,
  output logic                             done,
  output logic                             found,
  output logic [thk_pkg::START_W-1:0]      start_index,
  output logic [thk_pkg::FLEX_W-1:0]       flex_used,
  output logic [thk_pkg::COUNT_W-1:0]      entry_count
);
  import thk_pkg::*;

  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int CW    = CNT_W + 5;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MATCH = 3'b010,
    ST_TRIM  = 3'b100
  } state_t;

  state_t state, state_next;

  // control state
  logic [CNT_W-1:0] held, held_next;
  logic [CNT_W-1:0] keep_tgt, keep_tgt_next;
  logic [AGE_W-1:0] lifespan;
  logic             done_next;

  // query words latched at capture
  logic [PLEN_W-1:0] plen_q;
  logic [FLEX_W-1:0] flex_q;

  // result next values
  logic               found_next;
  logic [IDX_W-1:0]   start_next;
  logic [FLEX_W-1:0]  used_next;

  logic               accept;
  logic               full;
  logic               keep_hit;
  logic               shift_all;
  logic [AGE_W-1:0]   limit;
  logic [KEY_BITS-1:0] new_key;
  logic [7:0]          code_ext;
  logic [2*PAT_WORD_W-1:0] pat_ext;

  logic [MAX_PATTERN-1:0][KEY_BITS-1:0]     pat_keys;
  cell_ctl_t [HISTORY_DEPTH-1:0]            ctl;
  logic [HISTORY_DEPTH-1:0][KEY_BITS-1:0]   cell_key;
  logic [HISTORY_DEPTH-1:0][STAMP_W-1:0]    cell_stamp;
  logic [HISTORY_DEPTH-1:0]                 cell_age_ok;
  logic [HISTORY_DEPTH-1:0][MAX_PATTERN-1:0] cell_key_eq;

  logic               hit;
  logic [IDX_W-1:0]   hit_start;
  logic [FLEX_W-1:0]  hit_used;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign full     = (held == CNT_W'(HISTORY_DEPTH));
  assign keep_hit = (keep_count != '0) && (CW'(keep_count) < CW'(held));
  assign limit    = (max_age_ms != '0) ? max_age_ms : lifespan;

  // key code trimmed or widened to the stored key width
  assign code_ext = {4'b0000, key_code};
  assign new_key  = code_ext[KEY_BITS-1:0];

  // pattern positions past bit 31 of the pattern word read as key 0
  assign pat_ext = {{PAT_WORD_W{1'b0}}, pattern_keys};

  genvar i, c;
  generate
    for (i = 0; i < MAX_PATTERN; i++) begin : g_pat
      if (i * KEY_BITS < PAT_WORD_W) begin : g_word
        assign pat_keys[i] = pat_ext[i*KEY_BITS +: KEY_BITS];
      end else begin : g_zero
        assign pat_keys[i] = '0;
      end
    end
  endgenerate

  // the whole row moves one cell toward the oldest end on a full push,
  // a remove from a non-empty history, or each trim cycle
  assign shift_all = (accept && (((kind == KIND_PUSH) && full) ||
                                 ((kind == KIND_REMOVE) && (held != '0)))) ||
                     (state == ST_TRIM);

  generate
    for (c = 0; c < HISTORY_DEPTH; c++) begin : g_cell
      logic [KEY_BITS-1:0] up_key;
      logic [STAMP_W-1:0]  up_stamp;

      // a push that is not full writes the first free cell
      assign ctl[c].load    = accept && (kind == KIND_PUSH) && !full &&
                              (held == CNT_W'(c));
      assign ctl[c].shift   = shift_all;
      assign ctl[c].capture = accept && (kind == KIND_QUERY);

      // the top cell takes the incoming key code and time stamp when the row shifts
      if (c == HISTORY_DEPTH - 1) begin : g_top
        assign up_key   = new_key;
        assign up_stamp = now_ms;
      end else begin : g_mid
        assign up_key   = cell_key[c+1];
        assign up_stamp = cell_stamp[c+1];
      end

      thk_cell #(
        .KEY_BITS    (KEY_BITS),
        .MAX_PATTERN (MAX_PATTERN)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl[c]),
        .new_key   (new_key),
        .new_stamp (now_ms),
        .up_key    (up_key),
        .up_stamp  (up_stamp),
        .now_ms    (now_ms),
        .limit     (limit),
        .pat_keys  (pat_keys),
        .key       (cell_key[c]),
        .stamp     (cell_stamp[c]),
        .age_ok    (cell_age_ok[c]),
        .key_eq    (cell_key_eq[c])
      );
    end
  endgenerate

  thk_window #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_PATTERN   (MAX_PATTERN),
    .CNT_W         (CNT_W),
    .IDX_W         (IDX_W)
  ) u_window (
    .age_ok    (cell_age_ok),
    .key_eq    (cell_key_eq),
    .plen      (plen_q),
    .flex      (flex_q),
    .held      (held),
    .hit       (hit),
    .hit_start (hit_start),
    .hit_used  (hit_used)
  );

  // sequencer
  always_comb begin
    state_next    = state;
    held_next     = held;
    keep_tgt_next = keep_tgt;
    done_next     = 1'b0;
    found_next    = 1'b0;
    start_next    = '0;
    used_next     = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          done_next = 1'b1;
          case (kind)
            KIND_PUSH: begin
              if (!full) begin
                held_next = held + 1'b1;
              end
            end
            KIND_QUERY: begin
              done_next  = 1'b0;
              state_next = ST_MATCH;
            end
            KIND_CLEAR: begin
              held_next = '0;
            end
            KIND_REMOVE: begin
              if (held != '0) begin
                held_next = held - 1'b1;
              end
            end
            KIND_KEEP: begin
              if (keep_hit) begin
                done_next     = 1'b0;
                state_next    = ST_TRIM;
                keep_tgt_next = CNT_W'(keep_count);
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_MATCH: begin
        done_next  = 1'b1;
        found_next = hit;
        start_next = hit_start;
        used_next  = hit_used;
        state_next = ST_IDLE;
      end
      ST_TRIM: begin
        held_next = held - 1'b1;
        if (held - 1'b1 == keep_tgt) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      held     <= '0;
      done     <= 1'b0;
      lifespan <= LIFESPAN_RESET;
    end else begin
      state <= state_next;
      held  <= held_next;
      done  <= done_next;
      if (cfg_write) begin
        lifespan <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    keep_tgt <= keep_tgt_next;
    if (accept && (kind == KIND_QUERY)) begin
      plen_q <= pattern_length;
      flex_q <= flex_mask;
    end
    if (done_next) begin
      found       <= found_next;
      start_index <= START_W'(start_next);
      flex_used   <= used_next;
      entry_count <= COUNT_W'(held_next);
    end
  end

`include "timed_key_history_wildcard_match_defines.svh"

  // a query never answers in the cycle after it is taken
  `THK_ASSERT_NEXT(a_query_two_cycles, accept && (kind == KIND_QUERY), busy && !done, "query result too early")
  // the window pick always ends in a result and frees the block
  `THK_ASSERT_NEXT(a_match_done, state == ST_MATCH, done && !busy, "match cycle gave no result")
  // push, clear and remove operations answer on the next cycle
  `THK_ASSERT_NEXT(a_quick_done, accept && ((kind == KIND_PUSH) || (kind == KIND_CLEAR) || (kind == KIND_REMOVE)), done, "missing result")
  // a result without a match carries no flex marks
  `THK_ASSERT_SAME(a_miss_clean, done && !found, (flex_used == '0) && (start_index == '0), "miss result not clean")

endmodule

`default_nettype wire
